// ===== rtl/odo_pkg.sv =====
// Shared types, constants and tables for the differential drive odometry core.
package odo_pkg;

  localparam int ODO_ANGLE_BITS = 16;
  localparam int CORDIC_STEPS   = 30;

  localparam logic [29:0] INV_TWO_PI  = 30'd683565276;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

  localparam logic [30:0] WHEEL_BASE_RST = 31'd5242880;

  // configuration register indexes
  localparam logic [1:0] REG_WHEEL_BASE    = 2'd0;
  localparam logic [1:0] REG_START_X       = 2'd1;
  localparam logic [1:0] REG_START_Y       = 2'd2;
  localparam logic [1:0] REG_START_HEADING = 2'd3;

  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_RELOAD = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] left_travel;
    logic signed [31:0] right_travel;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pose_x_out;
    logic signed [31:0] pose_y_out;
    logic        [15:0] heading_out;
  } odo_out_t;

  // arctan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] odo_atan(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      5'd20:   v = 30'h0000028C;
      5'd21:   v = 30'h00000146;
      5'd22:   v = 30'h000000A3;
      5'd23:   v = 30'h00000051;
      5'd24:   v = 30'h00000029;
      5'd25:   v = 30'h00000014;
      5'd26:   v = 30'h0000000A;
      5'd27:   v = 30'h00000005;
      5'd28:   v = 30'h00000003;
      5'd29:   v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/odo_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module odo_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [64:0] num,
  input  logic [33:0] den,
  output logic        done,
  output logic [64:0] quo
);

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [33:0] rem_r;
  logic [64:0] q_r;
  logic [33:0] den_r;
  logic [34:0] shifted;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    shifted = {rem_r, q_r[64]};
    trial   = {1'b0, shifted} - {2'b0, den_r};
    ge      = !trial[35];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? trial[33:0] : shifted[33:0];
      q_r   <= {q_r[63:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== rtl/odo_cordic.sv =====
// Iterative rotation-mode CORDIC: cosine and sine in Q30 of a 32-bit binary angle.
module odo_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import odo_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [4:0]         step_r;
  logic               neg_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [33:0] z_r;
  logic signed [33:0] sx;
  logic signed [33:0] sy;
  logic signed [33:0] at;
  logic               fold;
  logic [31:0]        a_fold;

  always_comb begin
    fold   = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    a_fold = fold ? {~angle[31], angle[30:0]} : angle;
    sx     = x_r >>> step_r;
    sy     = y_r >>> step_r;
    at     = signed'({4'b0, odo_atan(step_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= fold;
      x_r   <= signed'(CORDIC_GAIN);
      y_r   <= '0;
      z_r   <= {{2{a_fold[31]}}, a_fold};
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + at;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = neg_r ? -x_r : x_r;
  assign sin_o = neg_r ? -y_r : y_r;

endmodule

// ===== rtl/differential_drive_odometry_core.sv =====
// Differential drive odometry core: arc-model pose tracker with shared divider, CORDIC and multiplier.
// Each motion transfer carries left and right wheel travel and returns the new pose (x, y in
// Q16.16 mm, heading as a binary angle); a reload transfer sets the pose from the start
// registers. One item is in work at a time and in_stall stays high until it is done. A turning step
// waits twice on the serial divider (heading change and turn radius), runs the CORDIC twice, and
// multiplies and sequences; a step with equal wheel travel skips both divisions and the first
// CORDIC run, a step whose radius is out of range or whose rotation rounds to zero skips the
// first CORDIC run, and a reload goes straight to the output. The finished pose waits in an
// output register, so the next item can be taken while it is still stalled; the item after
// that waits for it.
// Configuration writes are always ready and should come only while the core is idle.
module differential_drive_odometry_core #(
  parameter int ANGLE_BITS = odo_pkg::ODO_ANGLE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  odo_pkg::odo_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output odo_pkg::odo_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import odo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_DIV1, S_MA0, S_MA1, S_MA2, S_MR, S_DIV2, S_ROT,
    S_MD1, S_MD2, S_MD3, S_HST, S_HEAD, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic        [30:0] wheel_base_r;
  logic signed [31:0] start_x_r;
  logic signed [31:0] start_y_r;
  logic        [15:0] start_heading_r;

  // pose
  logic signed [31:0]           pose_x_r;
  logic signed [31:0]           pose_y_r;
  logic        [ANGLE_BITS-1:0] heading_r;

  // per item work registers
  logic        [32:0]           ad_r;
  logic        [32:0]           as_r;
  logic signed [32:0]           sum_r;
  logic                         diff_neg_r;
  logic                         r_neg_r;
  logic        [64:0]           q1_r;
  logic        [63:0]           acc_lo_r;
  logic        [63:0]           acc_r;
  logic        [31:0]           d32_r;
  logic        [ANGLE_BITS-1:0] dab_r;
  logic signed [31:0]           rad_r;
  logic signed [35:0]           mx_r;
  logic signed [35:0]           my_r;
  logic signed [35:0]           t_r;
  logic signed [37:0]           dx_r;
  logic signed [37:0]           dy_r;
  logic signed [71:0]           prod_r;

  logic               out_valid_r;
  odo_out_t           out_data_r;

  // combinational helpers
  logic               in_xfer;
  logic               out_xfer;
  logic signed [32:0] in_dl;
  logic signed [32:0] in_dr;
  logic signed [32:0] in_diff;
  logic signed [32:0] in_sum;
  logic        [30:0] wb_eff;
  logic signed [35:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [71:0] prod_rnd;
  logic signed [35:0] rnd30;
  logic        [63:0] d32_sum;
  logic        [63:0] dab_sum;
  logic        [31:0] d32_val;
  logic [ANGLE_BITS-1:0] dab_val;
  logic               div_start;
  logic        [64:0] div_num;
  logic        [33:0] div_den;
  logic               div_done;
  logic        [64:0] div_quo;
  logic               cor_start;
  logic        [31:0] cor_angle;
  logic               cor_done;
  logic signed [33:0] cor_cos;
  logic signed [33:0] cor_sin;
  logic               arc_ok;
  logic signed [39:0] px_sum;
  logic signed [39:0] py_sum;
  logic        [23:0] hd_ext;
  logic        [23:0] hs_ext;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    in_dl    = {in_data.left_travel[31], in_data.left_travel};
    in_dr    = {in_data.right_travel[31], in_data.right_travel};
    in_diff  = in_dr - in_dl;
    in_sum   = in_dr + in_dl;
    wb_eff   = (wheel_base_r == '0) ? 31'd1 : wheel_base_r;
    prod_rnd = prod_r + 72'sd536870912;
    rnd30    = prod_rnd[65:30];
    d32_sum  = acc_r + 64'h80000000;
    dab_sum  = acc_r + (64'd1 << (63 - ANGLE_BITS));
    d32_val  = diff_neg_r ? -d32_sum[63:32] : d32_sum[63:32];
    dab_val  = diff_neg_r ? -dab_sum[63 -: ANGLE_BITS] : dab_sum[63 -: ANGLE_BITS];
    arc_ok   = (d32_r != '0) && (div_quo[64:31] == '0);
    px_sum   = {{8{pose_x_r[31]}}, pose_x_r} + {{2{dx_r[37]}}, dx_r};
    py_sum   = {{8{pose_y_r[31]}}, pose_y_r} + {{2{dy_r[37]}}, dy_r};
    hd_ext   = 24'(heading_r);
    hs_ext   = 24'(start_heading_r);
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MA0: begin
        mul_a = signed'({4'b0, q1_r[31:0]});
        mul_b = signed'({6'b0, INV_TWO_PI});
      end
      S_MA1: begin
        mul_a = signed'({4'b0, q1_r[63:32]});
        mul_b = signed'({6'b0, INV_TWO_PI});
      end
      S_MA2: begin
        mul_a = signed'({5'b0, wb_eff});
        mul_b = signed'({3'b0, as_r});
      end
      S_MD1: begin
        mul_a = {{4{rad_r[31]}}, rad_r};
        mul_b = {{2{cor_sin[33]}}, cor_sin};
      end
      S_MD2: begin
        mul_a = {{4{rad_r[31]}}, rad_r};
        mul_b = (36'sd1 <<< 30) - {{2{cor_cos[33]}}, cor_cos};
      end
      S_P1: begin
        mul_a = mx_r;
        mul_b = {{2{cor_cos[33]}}, cor_cos};
      end
      S_P2: begin
        mul_a = my_r;
        mul_b = {{2{cor_sin[33]}}, cor_sin};
      end
      S_P3: begin
        mul_a = mx_r;
        mul_b = {{2{cor_sin[33]}}, cor_sin};
      end
      S_P4: begin
        mul_a = my_r;
        mul_b = {{2{cor_cos[33]}}, cor_cos};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {ad_r, 32'b0};
    div_den   = {3'b0, wb_eff};
    if (state_r == S_PRE) begin
      div_start = (ad_r != '0);
    end else if (state_r == S_MR) begin
      div_start = 1'b1;
      div_num   = {1'b0, prod_r[63:0]};
      div_den   = {ad_r, 1'b0};
    end
    cor_start = ((state_r == S_DIV2) && div_done && arc_ok) || (state_r == S_HST);
    // place the heading at the top of the 32-bit angle
    cor_angle = (state_r == S_DIV2) ? d32_r : 32'({hd_ext, 8'b0} << (24 - ANGLE_BITS));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = (in_data.kind == KIND_RELOAD) ? S_OUT : S_PRE;
      S_PRE:  state_nxt = (ad_r == '0) ? S_HST : S_DIV1;
      S_DIV1: if (div_done) state_nxt = S_MA0;
      S_MA0:  state_nxt = S_MA1;
      S_MA1:  state_nxt = S_MA2;
      S_MA2:  state_nxt = S_MR;
      S_MR:   state_nxt = S_DIV2;
      S_DIV2: if (div_done) state_nxt = arc_ok ? S_ROT : S_HST;
      S_ROT:  if (cor_done) state_nxt = S_MD1;
      S_MD1:  state_nxt = S_MD2;
      S_MD2:  state_nxt = S_MD3;
      S_MD3:  state_nxt = S_HST;
      S_HST:  state_nxt = S_HEAD;
      S_HEAD: if (cor_done) state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_P3;
      S_P3:   state_nxt = S_P4;
      S_P4:   state_nxt = S_P5;
      S_P5:   state_nxt = S_P6;
      S_P6:   state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, configuration, pose and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      wheel_base_r    <= WHEEL_BASE_RST;
      start_x_r       <= '0;
      start_y_r       <= '0;
      start_heading_r <= '0;
      pose_x_r        <= '0;
      pose_y_r        <= '0;
      heading_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WHEEL_BASE:    wheel_base_r    <= cfg_data[30:0];
          REG_START_X:       start_x_r       <= cfg_data;
          REG_START_Y:       start_y_r       <= cfg_data;
          REG_START_HEADING: start_heading_r <= cfg_data[15:0];
          default:           wheel_base_r    <= wheel_base_r;
        endcase
      end
      if (in_xfer && in_data.kind == KIND_RELOAD) begin
        pose_x_r  <= start_x_r;
        pose_y_r  <= start_y_r;
        heading_r <= hs_ext[ANGLE_BITS-1:0];
      end
      if (state_r == S_P6) begin
        pose_x_r  <= sat32(px_sum);
        pose_y_r  <= sat32(py_sum);
        heading_r <= heading_r - dab_r;
      end
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_data_r.pose_x_out  <= pose_x_r;
      out_data_r.pose_y_out  <= pose_y_r;
      out_data_r.heading_out <= hd_ext[15:0];
    end
    if (in_xfer) begin
      ad_r       <= in_diff[32] ? 33'(-in_diff) : 33'(in_diff);
      as_r       <= in_sum[32] ? 33'(-in_sum) : 33'(in_sum);
      sum_r      <= in_sum;
      diff_neg_r <= in_diff[32];
      r_neg_r    <= in_sum[32] != in_diff[32];
      dab_r      <= '0;
      mx_r       <= {{4{in_sum[32]}}, in_sum[32:1]};
      my_r       <= '0;
    end
    if (state_r == S_DIV1 && div_done) q1_r <= div_quo;
    if (state_r == S_MA1) acc_lo_r <= prod_r[63:0];
    if (state_r == S_MA2) acc_r <= acc_lo_r + {prod_r[31:0], 32'b0};
    if (state_r == S_MR) begin
      d32_r <= d32_val;
      dab_r <= dab_val;
    end
    if (state_r == S_DIV2 && div_done) begin
      rad_r <= r_neg_r ? -{1'b0, div_quo[30:0]} : {1'b0, div_quo[30:0]};
      // hold the straight step when the arc is not usable
      mx_r  <= {{4{sum_r[32]}}, sum_r[32:1]};
      my_r  <= '0;
    end
    if (state_r == S_MD2) mx_r <= rnd30;
    if (state_r == S_MD3) my_r <= rnd30;
    if (state_r == S_P2) t_r <= rnd30;
    if (state_r == S_P3) dx_r <= 38'(t_r) + 38'(rnd30);
    if (state_r == S_P4) t_r <= rnd30;
    if (state_r == S_P5) dy_r <= 38'(t_r) - 38'(rnd30);
  end

  odo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  odo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/odo_chk.sv =====
// Port-level checker for the odometry core, bound to the top level.
module odo_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input odo_pkg::odo_out_t out_data
);

  // one item at a time: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item was in work");

  // a result appears only as the work on an item ends
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result shown without an item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind differential_drive_odometry_core odo_chk u_odo_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/differential_drive_odometry_core_tb.sv =====
// Self-checking testbench for the differential drive odometry core with a pose predictor.
`timescale 1ns / 1ps

class pose_scoreboard;
  bit [30:0]          wheel_base;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  bit [15:0]          start_heading;
  longint             pose_x;
  longint             pose_y;
  bit [15:0]          heading;
  odo_pkg::odo_out_t  expected_poses[$];
  int                 errors;
  int                 n_checked;
  int                 n_turns;
  int                 n_reloads;
  longint             atan_steps[30];

  function new();
    atan_steps = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
    wheel_base    = odo_pkg::WHEEL_BASE_RST;
    start_x       = 0;
    start_y       = 0;
    start_heading = 0;
    pose_x        = 0;
    pose_y        = 0;
    heading       = 0;
    errors        = 0;
    n_checked     = 0;
    n_turns       = 0;
    n_reloads     = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      odo_pkg::REG_WHEEL_BASE:    wheel_base = data[30:0];
      odo_pkg::REG_START_X:       start_x = data;
      odo_pkg::REG_START_Y:       start_y = data;
      odo_pkg::REG_START_HEADING: start_heading = data[15:0];
      default: ;
    endcase
  endfunction

  function longint round_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // cos/sin in Q30 of a 32-bit binary angle
  function void sin_cos(bit [31:0] a, output longint c, output longint s);
    bit     flip;
    longint x, y, z, t;
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_steps[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_steps[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function void note_transfer(odo_pkg::odo_in_t item);
    longint            dl, dr, diff, sum, mx, my, ch, sh, cd, sd, radius, dx, dy;
    bit [63:0]         base, ad, as, qi, fr, acc, rmag;
    bit [31:0]         d32;
    bit [15:0]         dab;
    bit                straight;
    odo_pkg::odo_out_t res;
    if (item.kind == odo_pkg::KIND_RELOAD) begin
      pose_x  = longint'(start_x);
      pose_y  = longint'(start_y);
      heading = start_heading;
      n_reloads++;
    end else begin
      dl       = longint'(item.left_travel);
      dr       = longint'(item.right_travel);
      diff     = dr - dl;
      sum      = dr + dl;
      base     = (wheel_base != 0) ? 64'(wheel_base) : 64'd1;
      dab      = 0;
      straight = 1;
      mx       = 0;
      my       = 0;
      if (diff != 0) begin
        ad   = (diff < 0) ? 64'(-diff) : 64'(diff);
        as   = (sum < 0) ? 64'(-sum) : 64'(sum);
        qi   = ad / base;
        fr   = ((ad % base) << 32) / base;
        acc  = ((qi * 64'(odo_pkg::INV_TWO_PI)) << 32) + fr * 64'(odo_pkg::INV_TWO_PI);
        d32  = 32'((acc + 64'h8000_0000) >> 32);
        rmag = (base * as) / (2 * ad);
        dab  = 16'((acc + (64'd1 << 47)) >> 48);
        if (diff < 0) begin
          d32 = -d32;
          dab = -dab;
        end
        if (d32 != 0 && rmag <= 64'h7FFF_FFFF) begin
          radius = longint'(rmag);
          if ((sum < 0) != (diff < 0)) radius = -radius;
          sin_cos(d32, cd, sd);
          mx = round_q30(radius * sd);
          my = round_q30(radius * ((64'sd1 <<< 30) - cd));
          straight = 0;
          n_turns++;
        end
      end
      if (straight) begin
        mx = sum >>> 1;
        my = 0;
      end
      sin_cos({heading, 16'h0000}, ch, sh);
      dx      = round_q30(mx * ch) + round_q30(my * sh);
      dy      = round_q30(mx * sh) - round_q30(my * ch);
      pose_x  = clamp32(pose_x + dx);
      pose_y  = clamp32(pose_y + dy);
      heading = heading - dab;
    end
    res.pose_x_out  = pose_x[31:0];
    res.pose_y_out  = pose_y[31:0];
    res.heading_out = heading;
    expected_poses.push_back(res);
  endfunction

  function void check_pose(odo_pkg::odo_out_t got);
    odo_pkg::odo_out_t exp_pose;
    if (expected_poses.size() == 0) begin
      $display("%0t: unexpected pose x=%0d y=%0d h=%0d", $realtime,
               got.pose_x_out, got.pose_y_out, got.heading_out);
      errors++;
      return;
    end
    exp_pose = expected_poses.pop_front();
    n_checked++;
    if (got.pose_x_out !== exp_pose.pose_x_out) begin
      $display("%0t: pose_x expected %0d actual %0d", $realtime,
               exp_pose.pose_x_out, got.pose_x_out);
      errors++;
    end
    if (got.pose_y_out !== exp_pose.pose_y_out) begin
      $display("%0t: pose_y expected %0d actual %0d", $realtime,
               exp_pose.pose_y_out, got.pose_y_out);
      errors++;
    end
    if (got.heading_out !== exp_pose.heading_out) begin
      $display("%0t: heading expected %0d actual %0d", $realtime,
               exp_pose.heading_out, got.heading_out);
      errors++;
    end
  endfunction
endclass

module differential_drive_odometry_core_tb;
  import odo_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  odo_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  odo_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [1:0]  cfg_index = REG_WHEEL_BASE;
  logic [31:0] cfg_data = '0;

  pose_scoreboard poses = new();
  bit idling_on = 1'b1;
  int hold_left = 0;
  int quiet_cycles = 0;

  differential_drive_odometry_core dut (.*);

  always #6 clk = ~clk;

  // monitor both channels and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) poses.note_transfer(in_data);
      if (out_valid && !out_stall) poses.check_pose(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
          || (poses.expected_poses.size() == 0 && !in_valid))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold when requested
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(0, 8);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_item(odo_in_t item);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_motion(logic [31:0] left, logic [31:0] right);
    odo_in_t item;
    item.kind         = KIND_MOTION;
    item.left_travel  = left;
    item.right_travel = right;
    send_item(item);
  endtask

  task automatic send_reload();
    odo_in_t item;
    item.kind         = KIND_RELOAD;
    item.left_travel  = $urandom();
    item.right_travel = $urandom();
    send_item(item);
  endtask

  // hold until every pose is back and the core has settled
  task automatic drain();
    while (poses.expected_poses.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    poses.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item();
    int          pick;
    logic [31:0] base, delta;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_reload();
    end else if (pick < 20) begin
      send_motion($urandom(), $urandom());
    end else if (pick < 30) begin
      base = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      send_motion(base, base);
    end else begin
      // ordinary encoder steps: a few mm per wheel, modest difference
      base  = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      delta = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      send_motion(base, base + delta);
    end
  endtask

  initial begin
    logic [31:0] wheel_set[6];
    wheel_set = '{32'd5242880, 32'd65536, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd2000000};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes and corner cases under reset configuration
    send_motion(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_motion(32'h8000_0000, 32'h7FFF_FFFF);
    send_motion(32'h7FFF_FFFF, 32'h8000_0000);
    send_motion(32'h8000_0000, 32'h8000_0000);
    send_motion(32'h4000_0000, 32'h4000_0001);   // radius too large: straight step
    send_motion(32'h0001_0000, 32'h0002_0000);
    send_motion(32'h0002_0000, 32'h0001_0000);
    send_motion(32'hFFFF_0000, 32'h0001_0000);   // spin in place
    send_motion(32'd0, 32'd0);
    send_reload();
    drain();
    write_reg(REG_START_X, 32'h7FFF_0000);
    write_reg(REG_START_Y, 32'h8000_0000);
    write_reg(REG_START_HEADING, 32'hFFFF_C000);
    send_reload();
    send_motion(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // saturate y
    send_motion(32'h0100_0000, 32'h0100_0000);
    send_motion(32'h0040_0000, 32'h0000_0000);   // turn on the left wheel only
    drain();
    write_reg(REG_WHEEL_BASE, 32'h7FFF_FFFF);
    send_motion(32'd100, 32'd101);               // rotation rounds to zero
    send_motion(32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    write_reg(REG_WHEEL_BASE, 32'd0);
    send_motion(32'd5, 32'd9);
    send_motion(32'h1234_5678, 32'h8765_4321);
    send_reload();
    drain();

    // random phases across wheel base and start pose settings
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_WHEEL_BASE, wheel_set[phase]);
      write_reg(REG_START_X, (phase == 1) ? 32'h8000_0000 : $urandom());
      write_reg(REG_START_Y, (phase == 2) ? 32'h7FFF_FFFF : $urandom());
      write_reg(REG_START_HEADING, (phase == 3) ? 32'hFFFF : $urandom_range(0, 65535));
      idling_on = (phase != 5) && (phase != 2);
      send_reload();
      for (int n = 0; n < 315; n++) begin
        if (phase == 1 && n == 40) hold_left = 2500;
        if (phase == 4 && n == 150) idling_on = 1'b0;
        if (phase == 4 && n == 220) idling_on = 1'b1;
        random_item();
      end
      drain();
    end

    idling_on = 1'b0;
    repeat (300) @(negedge clk);
    $display("Checked %0d poses: %0d arc turns, %0d reloads, six wheel base settings.",
             poses.n_checked, poses.n_turns, poses.n_reloads);
    if (poses.errors == 0 && poses.expected_poses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d poses missing", poses.errors,
               poses.expected_poses.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
